@@ hdl/tlscpu_pkg.sv @@
// tlscpu_pkg: shared types and constants of the tiny load/store processor core
// depends on nothing; used by tiny_load_store_cpu_core
package tlscpu_pkg;

	// default geometry
	localparam int PAGE_BYTES_DEF = 16384;
	localparam int NUM_REGS       = 16;
	localparam int REG_AW         = $clog2(NUM_REGS);

	// commands
	localparam logic [2:0] CMD_WRITE_PROG = 3'd0;
	localparam logic [2:0] CMD_WRITE_REG  = 3'd1;
	localparam logic [2:0] CMD_STEP       = 3'd2;
	localparam logic [2:0] CMD_READ_REG   = 3'd3;
	localparam logic [2:0] CMD_RESTART    = 3'd4;

	// opcodes
	localparam logic [7:0] OP_SET   = 8'd0;
	localparam logic [7:0] OP_STORE = 8'd1;
	localparam logic [7:0] OP_LOAD  = 8'd2;
	localparam logic [7:0] OP_ADD   = 8'd3;
	localparam logic [7:0] OP_HALT  = 8'd4;

	// access width selects
	localparam logic [1:0] WSEL_BYTE = 2'd0;
	localparam logic [1:0] WSEL_HALF = 2'd1;
	localparam logic [1:0] WSEL_WORD = 2'd2;
	localparam logic [1:0] WSEL_BAD  = 2'd3;

	// status codes
	localparam logic [3:0] ST_OK          = 4'd0;
	localparam logic [3:0] ST_HALTED      = 4'd1;
	localparam logic [3:0] ST_MISALIGNED  = 4'd2;
	localparam logic [3:0] ST_UNMAPPED    = 4'd3;
	localparam logic [3:0] ST_ROM_WRITE   = 4'd4;
	localparam logic [3:0] ST_BAD_CONSOLE = 4'd5;
	localparam logic [3:0] ST_BAD_OPCODE  = 4'd6;
	localparam logic [3:0] ST_BAD_WIDTH   = 4'd7;
	localparam logic [3:0] ST_PC_OUT      = 4'd8;

	// command transaction
	typedef struct packed {
		logic [2:0]  command;
		logic [11:0] index;
		logic [31:0] data;
	} cmd_t;

	// result transaction
	typedef struct packed {
		logic [3:0]  status;
		logic        console_valid;
		logic [7:0]  console_byte;
		logic [31:0] read_data;
		logic        is_halted;
	} rsp_t;

endpackage

@@ hdl/tlscpu_ram.sv @@
// tlscpu_ram: generic single-write, single-read memory with registered read data
// depends on nothing
module tlscpu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/tiny_load_store_cpu_core.sv @@
// tiny_load_store_cpu_core: top level of the tiny load/store processor core
// depends on tlscpu_pkg and tlscpu_ram
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) takes one command transaction: write a
//   program word, write or read a register, restart at the ROM base, or step one
//   instruction. rsp channel (rsp_valid/rsp_ready/rsp) returns exactly one result
//   transaction per command, in order.
//   A simple command's result is loaded after a command stage, a read register
//   adds a register-file read, and a step adds fetch, up to two register-file
//   reads and one data access (none of these when halted or the program counter
//   is past the ROM), each through the single synchronous read port of the
//   register file or a page memory. The next command is taken in the cycle
//   after the result is loaded into the output register, so no new command is
//   accepted while the last one is still in progress.
//   After reset the program page, the data page and the register file are swept
//   to zero, one word per cycle over every word of a page, with cmd_ready low.
//   When the receiver stalls, the finished result waits in the output register;
//   a new command is still accepted and processed, and holds until the output
//   register is free.
module tiny_load_store_cpu_core #(
	parameter int PAGE_BYTES = tlscpu_pkg::PAGE_BYTES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  tlscpu_pkg::cmd_t  cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output tlscpu_pkg::rsp_t  rsp
);
	import tlscpu_pkg::*;

	localparam int PAGE_WORDS = PAGE_BYTES / 4;
	localparam int AW         = $clog2(PAGE_WORDS);
	localparam int PCW        = $clog2(PAGE_WORDS + 1);

	localparam logic [31:0] CON_BASE = 32'(PAGE_BYTES * 4);
	localparam logic [31:0] ROM_BASE = 32'(PAGE_BYTES * 5);
	localparam logic [31:0] RAM_BASE = 32'(PAGE_BYTES * 6);
	localparam logic [31:0] RAM_END  = 32'(PAGE_BYTES * 7);
	localparam logic [31:0] PW_LIMIT = 32'(PAGE_WORDS);

	// sequencer states
	localparam logic [3:0] S_CLEAR = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_CMD   = 4'd2;
	localparam logic [3:0] S_RDREG = 4'd3;
	localparam logic [3:0] S_FETCH = 4'd4;
	localparam logic [3:0] S_RA    = 4'd5;
	localparam logic [3:0] S_RB    = 4'd6;
	localparam logic [3:0] S_MEM   = 4'd7;
	localparam logic [3:0] S_DONE  = 4'd8;

	logic [3:0]     state_q;
	logic [AW-1:0]  clr_q;
	cmd_t           cmd_q;
	logic [PCW-1:0] pc_q;
	logic           halt_q;
	logic [31:0]    instr_q;
	logic [31:0]    rega_q;
	logic [31:0]    regb_q;
	logic           from_rom_q;
	logic [AW-1:0]  widx_q;
	logic [1:0]     sh_q;
	logic [3:0]     status_q;
	logic           cvalid_q;
	logic [7:0]     cbyte_q;
	logic [31:0]    rdata_q;
	rsp_t           rsp_q;
	logic           rsp_valid_q;

	// memory ports
	logic              prog_we, data_we, reg_we;
	logic [AW-1:0]     prog_waddr, prog_raddr, data_waddr, data_raddr;
	logic [31:0]       prog_wdata, data_wdata, reg_wdata;
	logic [31:0]       prog_rdata, data_rdata, reg_rdata;
	logic [REG_AW-1:0] reg_waddr, reg_raddr;

	// instruction fields
	logic [31:0]       cur_instr;
	logic [7:0]        op;
	logic [REG_AW-1:0] f0, f1, f2;
	logic [1:0]        wsel;
	logic              is_store;

	// address checks on the address register value
	logic              misaligned, in_con, in_rom, in_ram;
	logic [31:0]       off_rom, off_ram, mem_off;
	logic [31:0]       mask, word, load_val, store_val;
	logic [4:0]        shamt;

	// index and program counter helpers
	logic [31:0]       idx_ext, pc_ext;
	logic              idx_ok, pc_ok, out_free, rsp_load;

	assign idx_ext = 32'(cmd_q.index);
	assign pc_ext  = 32'(pc_q);
	assign idx_ok  = idx_ext < PW_LIMIT;
	assign pc_ok   = pc_ext < PW_LIMIT;

	// decode from fresh fetch data or the held instruction
	assign cur_instr = (state_q == S_FETCH) ? prog_rdata : instr_q;
	assign op        = cur_instr[7:0];
	assign f0        = cur_instr[8 +: REG_AW];
	assign f1        = cur_instr[12 +: REG_AW];
	assign f2        = cur_instr[16 +: REG_AW];
	assign wsel      = cur_instr[17:16];
	assign is_store  = (op == OP_STORE);

	// memory map decode
	assign misaligned = ((wsel == WSEL_HALF) && rega_q[0]) ||
		((wsel == WSEL_WORD) && (rega_q[1:0] != 2'b00));
	assign in_con  = (rega_q >= CON_BASE) && (rega_q < ROM_BASE);
	assign in_rom  = (rega_q >= ROM_BASE) && (rega_q < RAM_BASE);
	assign in_ram  = (rega_q >= RAM_BASE) && (rega_q < RAM_END);
	assign off_rom = rega_q - ROM_BASE;
	assign off_ram = rega_q - RAM_BASE;
	assign mem_off = in_ram ? off_ram : off_rom;

	// byte lane merge for loads and stores
	always_comb begin
		case (wsel)
			WSEL_BYTE: mask = 32'h0000_00ff;
			WSEL_HALF: mask = 32'h0000_ffff;
			default:   mask = 32'hffff_ffff;
		endcase
	end
	assign shamt     = {sh_q, 3'b000};
	assign word      = from_rom_q ? prog_rdata : data_rdata;
	assign load_val  = (regb_q & ~mask) | ((word >> shamt) & mask);
	assign store_val = (word & ~(mask << shamt)) | ((regb_q & mask) << shamt);

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign rsp_load  = (state_q == S_DONE) && out_free;
	assign cmd_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memory port control
	always_comb begin
		prog_we    = 1'b0;
		prog_waddr = '0;
		prog_wdata = '0;
		prog_raddr = '0;
		data_we    = 1'b0;
		data_waddr = '0;
		data_wdata = '0;
		data_raddr = '0;
		reg_we     = 1'b0;
		reg_waddr  = '0;
		reg_wdata  = '0;
		reg_raddr  = '0;
		case (state_q)
			S_CLEAR: begin
				prog_we    = 1'b1;
				prog_waddr = clr_q;
				data_we    = 1'b1;
				data_waddr = clr_q;
				reg_we     = 1'b1;
				reg_waddr  = clr_q[REG_AW-1:0];
			end
			S_CMD: begin
				case (cmd_q.command)
					CMD_WRITE_PROG: begin
						prog_we    = idx_ok;
						prog_waddr = idx_ext[AW-1:0];
						prog_wdata = cmd_q.data;
					end
					CMD_WRITE_REG: begin
						reg_we    = 1'b1;
						reg_waddr = cmd_q.index[REG_AW-1:0];
						reg_wdata = cmd_q.data;
					end
					CMD_READ_REG: begin
						reg_raddr = cmd_q.index[REG_AW-1:0];
					end
					CMD_STEP: begin
						prog_raddr = pc_q[AW-1:0];
					end
					default: begin
					end
				endcase
			end
			S_FETCH: begin
				if (op == OP_SET) begin
					reg_we    = 1'b1;
					reg_waddr = f0;
					reg_wdata = {12'd0, cur_instr[31:12]};
				end
				reg_raddr = is_store ? f0 : f1;
			end
			S_RA: begin
				if (op == OP_ADD) begin
					reg_raddr = f2;
				end else if (is_store) begin
					reg_raddr = f1;
				end else begin
					reg_raddr = f0;
				end
			end
			S_RB: begin
				if (op == OP_ADD) begin
					reg_we    = 1'b1;
					reg_waddr = f0;
					reg_wdata = rega_q + reg_rdata;
				end
				prog_raddr = mem_off[AW+1:2];
				data_raddr = mem_off[AW+1:2];
			end
			S_MEM: begin
				if (is_store) begin
					data_we    = 1'b1;
					data_waddr = widx_q;
					data_wdata = store_val;
				end else begin
					reg_we    = 1'b1;
					reg_waddr = f0;
					reg_wdata = load_val;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			cmd_q      <= '0;
			pc_q       <= '0;
			halt_q     <= 1'b0;
			instr_q    <= '0;
			rega_q     <= '0;
			regb_q     <= '0;
			from_rom_q <= 1'b0;
			widx_q     <= '0;
			sh_q       <= '0;
			status_q   <= ST_OK;
			cvalid_q   <= 1'b0;
			cbyte_q    <= '0;
			rdata_q    <= '0;
			rsp_q      <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(PAGE_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q    <= cmd;
						status_q <= ST_OK;
						cvalid_q <= 1'b0;
						cbyte_q  <= '0;
						rdata_q  <= '0;
						state_q  <= S_CMD;
					end
				end
				S_CMD: begin
					state_q <= S_DONE;
					case (cmd_q.command)
						CMD_READ_REG: begin
							state_q <= S_RDREG;
						end
						CMD_RESTART: begin
							pc_q   <= '0;
							halt_q <= 1'b0;
						end
						CMD_STEP: begin
							if (halt_q) begin
								status_q <= ST_HALTED;
							end else if (!pc_ok) begin
								status_q <= ST_PC_OUT;
								halt_q   <= 1'b1;
							end else begin
								pc_q    <= PCW'(pc_q + 1'b1);
								state_q <= S_FETCH;
							end
						end
						default: begin
						end
					endcase
				end
				S_RDREG: begin
					rdata_q <= reg_rdata;
					state_q <= S_DONE;
				end
				S_FETCH: begin
					instr_q <= prog_rdata;
					state_q <= S_DONE;
					case (op)
						OP_SET: begin
						end
						OP_ADD: begin
							state_q <= S_RA;
						end
						OP_HALT: begin
							status_q <= ST_HALTED;
							halt_q   <= 1'b1;
						end
						default: begin
							if (op inside {OP_STORE, OP_LOAD}) begin
								if (wsel == WSEL_BAD) begin
									status_q <= ST_BAD_WIDTH;
									halt_q   <= 1'b1;
								end else begin
									state_q <= S_RA;
								end
							end else begin
								status_q <= ST_BAD_OPCODE;
								halt_q   <= 1'b1;
							end
						end
					endcase
				end
				S_RA: begin
					rega_q  <= reg_rdata;
					state_q <= S_RB;
				end
				S_RB: begin
					regb_q     <= reg_rdata;
					from_rom_q <= !in_ram;
					widx_q     <= mem_off[AW+1:2];
					sh_q       <= mem_off[1:0];
					state_q    <= S_DONE;
					if (op != OP_ADD) begin
						if (misaligned) begin
							status_q <= ST_MISALIGNED;
							halt_q   <= 1'b1;
						end else if (in_con) begin
							if (is_store && (wsel == WSEL_BYTE) && (rega_q == CON_BASE)) begin
								cvalid_q <= 1'b1;
								cbyte_q  <= reg_rdata[7:0];
							end else begin
								status_q <= ST_BAD_CONSOLE;
								halt_q   <= 1'b1;
							end
						end else if (in_ram) begin
							state_q <= S_MEM;
						end else if (in_rom) begin
							if (is_store) begin
								status_q <= ST_ROM_WRITE;
								halt_q   <= 1'b1;
							end else begin
								state_q <= S_MEM;
							end
						end else begin
							status_q <= ST_UNMAPPED;
							halt_q   <= 1'b1;
						end
					end
				end
				S_MEM: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_q.status        <= status_q;
						rsp_q.console_valid <= cvalid_q;
						rsp_q.console_byte  <= cbyte_q;
						rsp_q.read_data     <= rdata_q;
						rsp_q.is_halted     <= halt_q;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result valid: set on load, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// program page (ROM)
	tlscpu_ram #(
		.WIDTH(32),
		.DEPTH(PAGE_WORDS)
	) u_prog_ram (
		.clk  (clk),
		.we   (prog_we),
		.waddr(prog_waddr),
		.wdata(prog_wdata),
		.raddr(prog_raddr),
		.rdata(prog_rdata)
	);

	// data page (RAM)
	tlscpu_ram #(
		.WIDTH(32),
		.DEPTH(PAGE_WORDS)
	) u_data_ram (
		.clk  (clk),
		.we   (data_we),
		.waddr(data_waddr),
		.wdata(data_wdata),
		.raddr(data_raddr),
		.rdata(data_rdata)
	);

	// register file
	tlscpu_ram #(
		.WIDTH(32),
		.DEPTH(NUM_REGS)
	) u_reg_ram (
		.clk  (clk),
		.we   (reg_we),
		.waddr(reg_waddr),
		.wdata(reg_wdata),
		.raddr(reg_raddr),
		.rdata(reg_rdata)
	);

endmodule
